>>> rtl/mlfq_three_level_scheduler_unit_defines.svh
// Assertion macros for the three-level feedback-queue scheduler.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef MLFQ_THREE_LEVEL_SCHEDULER_UNIT_DEFINES_SVH
`define MLFQ_THREE_LEVEL_SCHEDULER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MLFQ_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after an antecedent.
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mlfq_pkg.sv
// Shared types, constants and helper functions of the feedback-queue scheduler.
// No dependencies; the RAM, the core and the top level import this package.
package mlfq_pkg;

  localparam int TASKS_DEF = 16;
  localparam int LEVELS = 3;
  localparam int TASK_ID_W = 5;

  localparam logic [15:0] BOOST_INTERVAL_RST = 16'd25;
  localparam logic [7:0] QUANTUM_ONE_RST = 8'd2;
  localparam logic [7:0] QUANTUM_TWO_RST = 8'd4;
  localparam logic [7:0] QUANTUM_THREE_RST = 8'd8;
  localparam logic [7:0] BOOST_CAP = 8'd2;

  typedef enum logic [1:0] {
    FUNC_NEW   = 2'd0,
    FUNC_BURST = 2'd1,
    FUNC_EXIT  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_IDLE   = 3'd0,
    KIND_RUN    = 3'd1,
    KIND_NEW    = 3'd2,
    KIND_EXIT   = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_BOOST_INTERVAL = 2'd0,
    REG_QUANTUM_ONE    = 2'd1,
    REG_QUANTUM_TWO    = 2'd2,
    REG_QUANTUM_THREE  = 2'd3
  } cfg_idx_t;

  // One entry of the per-task memory.
  typedef struct packed {
    logic        active;
    logic [1:0]  level;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [31:0] wait_cnt;
    logic [31:0] exec_cnt;
  } task_rec_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] tick_number;
    logic        boosted;
    logic [4:0]  running_task;
    logic [15:0] requested;
    logic [15:0] used;
    logic [1:0]  run_level;
    logic [31:0] wait_total;
    logic [31:0] turnaround;
  } res_t;

  typedef struct packed {
    logic [15:0] boost_interval;
    logic [7:0]  quantum_one;
    logic [7:0]  quantum_two;
    logic [7:0]  quantum_three;
  } cfg_t;

  typedef struct packed {
    logic       busy;
    logic [4:0] current_task;
    logic [5:0] queued;
  } status_t;

  // Saturating increment of a 32-bit statistic.
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

>>> rtl/mlfq_ifs.sv
// Channel interfaces of the scheduler: input events, results, configuration writes.
// Depends on nothing; field widths are fixed by the block's item format.
interface mlfq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [4:0]  task_number;
  logic [15:0] burst_length;
  modport source(output valid, func, task_number, burst_length, input ready);
  modport sink(input valid, func, task_number, burst_length, output ready);
endinterface

interface mlfq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] tick_number;
  logic        boosted;
  logic [4:0]  running_task;
  logic [15:0] requested;
  logic [15:0] used;
  logic [1:0]  run_level;
  logic [31:0] wait_total;
  logic [31:0] turnaround;
  modport source(output valid, kind, tick_number, boosted, running_task, requested, used,
                 run_level, wait_total, turnaround, input ready);
  modport sink(input valid, kind, tick_number, boosted, running_task, requested, used,
               run_level, wait_total, turnaround, output ready);
endinterface

interface mlfq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/mlfq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Depends on mlfq_pkg for default sizes.
module mlfq_ram import mlfq_pkg::*; #(
  parameter int WIDTH = TASK_ID_W,
  parameter int DEPTH = TASKS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mlfq_core.sv
// Scheduler sequencer: per-task memory, queue memory and the control that walks them.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_core import mlfq_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_task,
  input  logic [15:0] in_blen,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res,
  input  cfg_t        cfg,
  input  logic        cfg_reload,
  input  logic [15:0] cfg_reload_val,
  output status_t     status
);

  localparam int TAW = $clog2(TASKS + 1);
  localparam int IW = $clog2(TASKS);
  localparam int CW = $clog2(TASKS + 1);
  localparam int CW1 = CW + 1;
  localparam int FDEPTH = LEVELS * TASKS;
  localparam int FAW = $clog2(FDEPTH);
  localparam int RECW = $bits(task_rec_t);
  localparam logic [4:0] TASK_MAX = 5'(TASKS);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_EVRD = 17'h00002,
    S_EV   = 17'h00004,
    S_TICK = 17'h00008,
    S_BCWR = 17'h00010,
    S_BM   = 17'h00020,
    S_BMF  = 17'h00040,
    S_BMT  = 17'h00080,
    S_SCH  = 17'h00100,
    S_DM   = 17'h00200,
    S_PICK = 17'h00400,
    S_PRE  = 17'h00800,
    S_POP  = 17'h01000,
    S_SW   = 17'h02000,
    S_SWE  = 17'h04000,
    S_FIN  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t state;

  logic [IW-1:0] head [LEVELS];
  logic [CW-1:0] cnt [LEVELS];
  logic [4:0] cur;
  logic [7:0] quantum;
  logic [31:0] tick_count;
  logic [15:0] countdown;
  logic [1:0] ev_func;
  logic [4:0] ev_task;
  logic [15:0] ev_blen;
  logic [4:0] mv_task;
  logic [TAW-1:0] sw;
  logic [TAW-1:0] widx;
  logic rv;
  logic cur_fin;
  res_t res;
  logic [TASKS:0] vld;
  logic vld_q;

  logic tm_we;
  logic [TAW-1:0] tm_waddr;
  logic [TAW-1:0] tm_raddr;
  task_rec_t tm_wdata;
  logic [RECW-1:0] tm_q;
  logic fm_we;
  logic [FAW-1:0] fm_waddr;
  logic [FAW-1:0] fm_raddr;
  logic [4:0] fm_wdata;
  logic [4:0] fm_q;

  // Queue slot address within the shared queue memory.
  function automatic logic [FAW-1:0] faddr(input logic [1:0] q, input logic [IW-1:0] idx);
    return FAW'(q) * FAW'(TASKS) + FAW'(idx);
  endfunction

  function automatic logic [IW-1:0] hnext(input logic [IW-1:0] h);
    return (h == IW'(TASKS - 1)) ? '0 : h + IW'(1);
  endfunction

  function automatic logic [IW-1:0] tail(input logic [IW-1:0] h, input logic [CW-1:0] c);
    logic [CW1-1:0] s;
    s = CW1'(h) + CW1'(c);
    if (s >= CW1'(TASKS)) begin
      s = s - CW1'(TASKS);
    end
    return IW'(s);
  endfunction

  function automatic logic [7:0] qfor(input logic [1:0] lvl, input cfg_t c);
    logic [7:0] q;
    case (lvl)
      2'd1: q = c.quantum_one;
      2'd2: q = c.quantum_two;
      default: q = c.quantum_three;
    endcase
    return (q == 8'd0) ? 8'd1 : q;
  endfunction

  // Per-task records; entries never written read as zero through the valid bits.
  mlfq_ram #(.WIDTH(RECW), .DEPTH(TASKS + 1)) u_task_ram (
    .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
    .raddr(tm_raddr), .rdata(tm_q)
  );

  // Three round-robin queues of task numbers, TASKS slots each.
  mlfq_ram #(.WIDTH(TASK_ID_W), .DEPTH(FDEPTH)) u_fifo_ram (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_q)
  );

  task_rec_t rec;
  task_rec_t wb_rec;
  logic [1:0] best;
  logic [1:0] best_q;
  logic [1:0] bm_q;
  logic bm_any;
  logic [1:0] ev_lvl;
  logic burst_ok;
  logic [1:0] dm_lvl;
  logic wb_is_cur;
  logic [32:0] tat_sum;
  logic [31:0] tat;

  // Decoded view of the record read in the previous cycle.
  always_comb begin
    rec = vld_q ? task_rec_t'(tm_q) : '0;
    best = (cnt[0] != '0) ? 2'd1 : (cnt[1] != '0) ? 2'd2 : (cnt[2] != '0) ? 2'd3 : 2'd0;
    best_q = best - 2'd1;
    bm_any = (cnt[2] != '0) || (cnt[1] != '0);
    bm_q = (cnt[2] != '0) ? 2'd2 : 2'd1;
    ev_lvl = (rec.level == 2'd0) ? 2'd1 : rec.level;
    burst_ok = (ev_blen != 16'd0) && rec.active && (rec.remaining == 16'd0);
    dm_lvl = (rec.level < 2'd3) ? rec.level + 2'd1 : 2'd3;
    tat_sum = {1'b0, rec.wait_cnt} + {1'b0, rec.exec_cnt};
    tat = tat_sum[32] ? 32'hFFFF_FFFF : tat_sum[31:0];
    wb_is_cur = (5'(widx) == cur);
    wb_rec = rec;
    if (wb_is_cur) begin
      wb_rec.exec_cnt = sat_inc32(rec.exec_cnt);
      if (rec.remaining != 16'd0) begin
        wb_rec.remaining = rec.remaining - 16'd1;
      end
    end else if (rec.active && rec.remaining != 16'd0) begin
      wb_rec.wait_cnt = sat_inc32(rec.wait_cnt);
    end
  end

  // Memory port control per sequencer step.
  always_comb begin
    tm_we = 1'b0;
    tm_waddr = '0;
    tm_wdata = rec;
    tm_raddr = '0;
    fm_we = 1'b0;
    fm_waddr = '0;
    fm_wdata = cur;
    fm_raddr = '0;
    unique case (state)
      S_EVRD: tm_raddr = TAW'(ev_task);
      S_EV: begin
        tm_waddr = TAW'(ev_task);
        fm_wdata = ev_task;
        fm_waddr = faddr(ev_lvl - 2'd1, tail(head[ev_lvl - 2'd1], cnt[ev_lvl - 2'd1]));
        case (ev_func)
          FUNC_NEW: begin
            tm_we = 1'b1;
            tm_wdata.active = 1'b1;
          end
          FUNC_BURST: begin
            tm_we = burst_ok;
            fm_we = burst_ok;
            tm_wdata.level = ev_lvl;
            tm_wdata.burst = ev_blen;
            tm_wdata.remaining = ev_blen;
          end
          default: begin
            tm_we = 1'b1;
            tm_wdata.active = 1'b0;
          end
        endcase
      end
      S_TICK: tm_raddr = TAW'(cur);
      S_BCWR: begin
        tm_we = 1'b1;
        tm_waddr = TAW'(cur);
        tm_wdata.level = 2'd1;
      end
      S_BM: fm_raddr = faddr(bm_q, head[bm_q]);
      S_BMF: tm_raddr = TAW'(fm_q);
      S_BMT: begin
        tm_we = 1'b1;
        tm_waddr = TAW'(mv_task);
        tm_wdata.level = 2'd1;
        fm_we = 1'b1;
        fm_waddr = faddr(2'd0, tail(head[0], cnt[0]));
        fm_wdata = mv_task;
      end
      S_SCH: tm_raddr = TAW'(cur);
      S_DM: begin
        tm_we = 1'b1;
        tm_waddr = TAW'(cur);
        tm_wdata.level = dm_lvl;
        fm_we = 1'b1;
        fm_waddr = faddr(dm_lvl - 2'd1, tail(head[dm_lvl - 2'd1], cnt[dm_lvl - 2'd1]));
      end
      S_PICK: begin
        tm_raddr = TAW'(cur);
        fm_raddr = faddr(best_q, head[best_q]);
      end
      S_PRE: begin
        fm_we = (rec.level > best);
        fm_waddr = faddr(rec.level - 2'd1, tail(head[rec.level - 2'd1], cnt[rec.level - 2'd1]));
        fm_raddr = faddr(best_q, head[best_q]);
      end
      S_SW: begin
        tm_raddr = sw;
        tm_we = rv;
        tm_waddr = widx;
        tm_wdata = wb_rec;
      end
      S_SWE: begin
        tm_we = 1'b1;
        tm_waddr = widx;
        tm_wdata = wb_rec;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign status.busy = (state != S_IDLE);
  assign status.current_task = cur;
  assign status.queued = 6'(cnt[0]) + 6'(cnt[1]) + 6'(cnt[2]);

  // Sequencer, queue pointers and scheduler registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int q = 0; q < LEVELS; q++) begin
        head[q] <= '0;
        cnt[q] <= '0;
      end
      cur <= '0;
      quantum <= '0;
      tick_count <= 32'd1;
      countdown <= BOOST_INTERVAL_RST - 16'd1;
      out_valid <= 1'b0;
      vld <= '0;
      vld_q <= 1'b0;
      rv <= 1'b0;
      cur_fin <= 1'b0;
    end else begin
      vld_q <= vld[tm_raddr];
      if (tm_we) begin
        vld[tm_waddr] <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_reload) begin
        countdown <= cfg_reload_val;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ev_func <= in_func;
            ev_task <= in_task;
            ev_blen <= in_blen;
            res <= '0;
            res.tick_number <= tick_count;
            if (func_t'(in_func) == FUNC_TICK) begin
              state <= S_TICK;
            end else begin
              res.running_task <= in_task;
              if (in_task == 5'd0 || in_task > TASK_MAX) begin
                res.kind <= KIND_REJECT;
                state <= S_OUT;
              end else begin
                state <= S_EVRD;
              end
            end
          end
        end
        S_EVRD: state <= S_EV;
        S_EV: begin
          case (ev_func)
            FUNC_NEW: res.kind <= KIND_NEW;
            FUNC_BURST: begin
              res.kind <= KIND_REJECT;
              if (burst_ok) begin
                cnt[ev_lvl - 2'd1] <= cnt[ev_lvl - 2'd1] + CW'(1);
                res.requested <= ev_blen;
                res.run_level <= ev_lvl;
              end
            end
            default: begin
              res.kind <= KIND_EXIT;
              res.wait_total <= rec.wait_cnt;
              res.turnaround <= tat;
            end
          endcase
          state <= S_OUT;
        end
        S_TICK: begin
          if (countdown == 16'd0) begin
            res.boosted <= 1'b1;
            countdown <= (cfg.boost_interval == 16'd0) ? 16'd0 : cfg.boost_interval - 16'd1;
            if (cur != 5'd0) begin
              if (quantum > BOOST_CAP) begin
                quantum <= BOOST_CAP;
              end
              state <= S_BCWR;
            end else begin
              state <= S_BM;
            end
          end else begin
            countdown <= countdown - 16'd1;
            state <= S_SCH;
          end
        end
        S_BCWR: state <= S_BM;
        // Boost drains level three, then level two, into level one.
        S_BM: begin
          if (bm_any) begin
            head[bm_q] <= hnext(head[bm_q]);
            cnt[bm_q] <= cnt[bm_q] - CW'(1);
            state <= S_BMF;
          end else begin
            state <= S_SCH;
          end
        end
        S_BMF: begin
          mv_task <= fm_q;
          state <= S_BMT;
        end
        S_BMT: begin
          cnt[0] <= cnt[0] + CW'(1);
          state <= S_BM;
        end
        S_SCH: begin
          if (cur != 5'd0 && quantum == 8'd0) begin
            state <= S_DM;
          end else begin
            state <= S_PICK;
          end
        end
        // Quantum expired: demote and requeue the running task.
        S_DM: begin
          cnt[dm_lvl - 2'd1] <= cnt[dm_lvl - 2'd1] + CW'(1);
          cur <= '0;
          state <= S_PICK;
        end
        S_PICK: begin
          if (best == 2'd0) begin
            sw <= TAW'(1);
            rv <= 1'b0;
            cur_fin <= 1'b0;
            state <= S_SW;
          end else if (cur == 5'd0) begin
            head[best_q] <= hnext(head[best_q]);
            cnt[best_q] <= cnt[best_q] - CW'(1);
            quantum <= qfor(best, cfg);
            state <= S_POP;
          end else begin
            state <= S_PRE;
          end
        end
        // Preemption by a strictly better level.
        S_PRE: begin
          if (rec.level > best) begin
            cnt[rec.level - 2'd1] <= cnt[rec.level - 2'd1] + CW'(1);
            head[best_q] <= hnext(head[best_q]);
            cnt[best_q] <= cnt[best_q] - CW'(1);
            quantum <= qfor(best, cfg);
            state <= S_POP;
          end else begin
            sw <= TAW'(1);
            rv <= 1'b0;
            cur_fin <= 1'b0;
            state <= S_SW;
          end
        end
        S_POP: begin
          cur <= fm_q;
          sw <= TAW'(1);
          rv <= 1'b0;
          cur_fin <= 1'b0;
          state <= S_SW;
        end
        // Counter sweep: read one task while the previous one is written back.
        S_SW: begin
          rv <= 1'b1;
          widx <= sw;
          if (rv && wb_is_cur) begin
            res.running_task <= cur;
            res.requested <= rec.burst;
            res.used <= rec.burst - wb_rec.remaining;
            res.run_level <= rec.level;
            cur_fin <= (wb_rec.remaining == 16'd0);
          end
          if (sw == TAW'(TASKS)) begin
            state <= S_SWE;
          end else begin
            sw <= sw + TAW'(1);
          end
        end
        S_SWE: begin
          if (wb_is_cur) begin
            res.running_task <= cur;
            res.requested <= rec.burst;
            res.used <= rec.burst - wb_rec.remaining;
            res.run_level <= rec.level;
            cur_fin <= (wb_rec.remaining == 16'd0);
          end
          rv <= 1'b0;
          state <= S_FIN;
        end
        // Execute: the running task consumes one tick of quantum.
        S_FIN: begin
          tick_count <= tick_count + 32'd1;
          if (cur != 5'd0) begin
            res.kind <= KIND_RUN;
            if (quantum != 8'd0) begin
              quantum <= quantum - 8'd1;
            end
            if (cur_fin) begin
              cur <= '0;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_res <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/mlfq_three_level_scheduler_unit.sv
// Top level of the three-level feedback-queue scheduler: channels, configuration registers.
// Depends on mlfq_pkg, mlfq_ifs, mlfq_core and the assertion macro header.
//
// One transaction at a time: an event (new, burst, exit) reads and updates the task record,
// or goes straight to the result when the task number is rejected; a tick is mostly the counter
// sweep through the per-task memory at one entry a cycle, plus steps for each task a boost
// moves and for a running task it finds. A finished result waits in the output register while
// the next transaction is accepted. Configuration writes are taken at any time.
`include "mlfq_three_level_scheduler_unit_defines.svh"

module mlfq_three_level_scheduler_unit import mlfq_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input logic        clk,
  input logic        rst,
  mlfq_in_if.sink    in_ch,
  mlfq_out_if.source out_ch,
  mlfq_cfg_if.sink   cfg_ch
);

  cfg_t cfg;
  res_t res;
  status_t st;
  logic cfg_reload;
  logic [15:0] cfg_reload_val;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  assign cfg_reload = cfg_ch.valid && (cfg_idx_t'(cfg_ch.index) == REG_BOOST_INTERVAL);
  assign cfg_reload_val = (cfg_ch.data == 16'd0) ? 16'd0 : cfg_ch.data - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boost_interval <= BOOST_INTERVAL_RST;
      cfg.quantum_one <= QUANTUM_ONE_RST;
      cfg.quantum_two <= QUANTUM_TWO_RST;
      cfg.quantum_three <= QUANTUM_THREE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        REG_BOOST_INTERVAL: cfg.boost_interval <= cfg_ch.data;
        REG_QUANTUM_ONE: cfg.quantum_one <= cfg_ch.data[7:0];
        REG_QUANTUM_TWO: cfg.quantum_two <= cfg_ch.data[7:0];
        REG_QUANTUM_THREE: cfg.quantum_three <= cfg_ch.data[7:0];
      endcase
    end
  end

  mlfq_core #(.TASKS(TASKS)) u_core (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_func(in_ch.func),
    .in_task(in_ch.task_number),
    .in_blen(in_ch.burst_length),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_res(res),
    .cfg(cfg),
    .cfg_reload(cfg_reload),
    .cfg_reload_val(cfg_reload_val),
    .status(st)
  );

  // Result fields.
  assign out_ch.kind = res.kind;
  assign out_ch.tick_number = res.tick_number;
  assign out_ch.boosted = res.boosted;
  assign out_ch.running_task = res.running_task;
  assign out_ch.requested = res.requested;
  assign out_ch.used = res.used;
  assign out_ch.run_level = res.run_level;
  assign out_ch.wait_total = res.wait_total;
  assign out_ch.turnaround = res.turnaround;

  // A task is never queued twice, so the queues together hold at most TASKS entries.
  `MLFQ_ASSERT_NOW(a_queue_bound, st.queued <= 6'(TASKS), "queues hold more than TASKS")
  `MLFQ_ASSERT_NOW(a_cur_range, st.current_task <= 5'(TASKS), "running task out of range")
  `MLFQ_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, st.busy, "not busy")

endmodule
